/* rtl/jsu_pkg.sv */
// Shared types, codes and helpers for the JSON string unescape unit.
// No dependencies; used by rtl/json_string_unescape_utf8_unit.sv.
`default_nettype none

package jsu_pkg;

	// Most results one input byte can cause: four UTF-8 bytes and an error.
	localparam int MaxRes = 5;

	typedef enum logic [5:0] {
		PH_NORMAL   = 6'b000001,
		PH_ESC      = 6'b000010,
		PH_HEX1     = 6'b000100,
		PH_WANT_BSL = 6'b001000,
		PH_WANT_U   = 6'b010000,
		PH_HEX2     = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		E_BAD_HEX    = 3'd0,
		E_BAD_ESC    = 3'd1,
		E_NO_LOW     = 3'd2,
		E_BAD_LOW    = 3'd3,
		E_LONE_LOW   = 3'd4,
		E_TRUNC_ESC  = 3'd5,
		E_TRUNC_UNI  = 3'd6,
		E_UNTERM     = 3'd7
	} err_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		err_t       err;
	} result_t;

	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] bytes;
	} utf8_t;

	// Characters of interest
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	// Top six bits of a high (D800..DBFF) and a low (DC00..DFFF) surrogate
	localparam logic [5:0] HI_SURR_TAG = 6'h36;
	localparam logic [5:0] LO_SURR_TAG = 6'h37;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;

	// Hex digit value; bit 4 set for a non-hex byte.
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = {1'b0, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			v = {1'b0, b[3:0] + 4'd9};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t u;
		u.bytes = '0;
		if (cp <= 21'h7F) begin
			u.len      = 3'd1;
			u.bytes[0] = {1'b0, cp[6:0]};
		end else if (cp <= 21'h7FF) begin
			u.len      = 3'd2;
			u.bytes[0] = {3'b110, cp[10:6]};
			u.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			u.len      = 3'd3;
			u.bytes[0] = {4'b1110, cp[15:12]};
			u.bytes[1] = {2'b10, cp[11:6]};
			u.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			u.len      = 3'd4;
			u.bytes[0] = {5'b11110, cp[20:18]};
			u.bytes[1] = {2'b10, cp[17:12]};
			u.bytes[2] = {2'b10, cp[11:6]};
			u.bytes[3] = {2'b10, cp[5:0]};
		end
		return u;
	endfunction

endpackage

`default_nettype wire

/* rtl/json_string_unescape_utf8_unit.sv */
// JSON string body unescaper with UTF-8 output, top level.
// Depends on rtl/jsu_pkg.sv.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per byte of a JSON
//   string body, starting after the opening quote, with end_of_line set on
//   the last byte of the line. Output channel (out_valid / out_stall) carries
//   one result word at a time: a decoded data byte, a string-closed marker or
//   an error code; last_of_run marks the final result caused by one input byte.
//   The first result of a byte is registered and visible the cycle after it
//   is accepted. One input byte per cycle is taken as long as each byte
//   yields at most one result and the receiver does not stall; a byte that
//   yields more than one result (a \u escape expanding to up to four UTF-8
//   bytes, plus a possible line-end error) holds in_stall high until its final
//   result leaves; the single result register drains a word each unstalled cycle.
//   Bytes that yield no result (escape prefixes, hex digits) add no stall.
//   A new byte is taken in the same cycle the last pending result leaves.
//   Reset puts the parser in the normal character phase and empties the
//   result register. When the receiver stalls, the pending result holds and
//   in_stall rises until the final result of the current byte is taken.
`default_nettype none

module json_string_unescape_utf8_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_line,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      result_kind,
	output logic [7:0]      data_byte,
	output logic [2:0]      error_code,
	output logic            last_of_run
);

	// Parser state
	jsu_pkg::phase_t phase_q;
	logic [1:0]      hex_cnt_q;
	logic [15:0]     code_unit_q;
	logic [9:0]      hi_bits_q;
	logic            bad_hex_q;

	// Result bundle of the last accepted byte, drained one word per cycle unless the receiver stalls
	jsu_pkg::result_t bundle_s1 [jsu_pkg::MaxRes];
	logic [2:0]       cnt_q;
	logic [2:0]       pos_q;

	// Handshake
	logic in_fire, out_fire, drain_done;

	assign out_valid  = (cnt_q != 3'd0);
	assign last_of_run = (pos_q == cnt_q - 3'd1);
	assign out_fire   = out_valid && !out_stall;
	assign drain_done = out_fire && last_of_run;
	assign in_stall   = out_valid && !drain_done;
	assign in_fire    = in_valid && !in_stall;

	assign result_kind = bundle_s1[pos_q].kind;
	assign data_byte   = bundle_s1[pos_q].data;
	assign error_code  = bundle_s1[pos_q].err;

	// Decode of the current byte
	jsu_pkg::phase_t  nx_phase;
	logic [1:0]       nx_hex_cnt;
	logic [15:0]      nx_code_unit;
	logic [9:0]       nx_hi_bits;
	logic             nx_bad_hex;

	logic [4:0]       hv;
	logic             hbad;
	logic [15:0]      cu_new;
	logic             bad_new;
	logic [20:0]      pair_cp;
	logic [20:0]      cp_sel;
	jsu_pkg::utf8_t   utf8;

	logic [2:0]       nd;          // data bytes produced
	logic [3:0][7:0]  db;
	logic             has_ctl;     // one end or error result instead of data
	jsu_pkg::result_t ctl;
	logic             done;
	logic             restart;
	jsu_pkg::phase_t  rs_phase;

	jsu_pkg::result_t res_d [jsu_pkg::MaxRes];
	logic [2:0]       n_d;

	assign hv      = jsu_pkg::hex_value(in_byte);
	assign hbad    = hv[4];
	assign cu_new  = {code_unit_q[11:0], hbad ? 4'h0 : hv[3:0]};
	assign bad_new = bad_hex_q | hbad;
	// Surrogate pair: 0x10000 + (high bits << 10) + low bits
	assign pair_cp = jsu_pkg::SUPP_BASE + {1'b0, hi_bits_q, cu_new[9:0]};
	assign cp_sel  = (phase_q == jsu_pkg::PH_HEX2) ? pair_cp : {5'd0, cu_new};
	assign utf8    = jsu_pkg::utf8_encode(cp_sel);

	always_comb begin
		nx_phase     = phase_q;
		nx_hex_cnt   = hex_cnt_q;
		nx_code_unit = code_unit_q;
		nx_hi_bits   = hi_bits_q;
		nx_bad_hex   = bad_hex_q;
		nd           = 3'd0;
		db           = '0;
		has_ctl      = 1'b0;
		ctl          = '{kind: jsu_pkg::KIND_END, data: 8'h00, err: jsu_pkg::E_BAD_HEX};
		done         = 1'b0;
		restart      = 1'b0;
		rs_phase     = jsu_pkg::PH_NORMAL;

		unique case (phase_q)
			jsu_pkg::PH_ESC: begin
				case (in_byte)
					jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: begin
						nd = 3'd1; db[0] = in_byte;
					end
					jsu_pkg::CH_B: begin nd = 3'd1; db[0] = 8'h08; end
					jsu_pkg::CH_F: begin nd = 3'd1; db[0] = 8'h0C; end
					jsu_pkg::CH_N: begin nd = 3'd1; db[0] = 8'h0A; end
					jsu_pkg::CH_R: begin nd = 3'd1; db[0] = 8'h0D; end
					jsu_pkg::CH_T: begin nd = 3'd1; db[0] = 8'h09; end
					jsu_pkg::CH_U: begin
						if (end_of_line) begin
							has_ctl = 1'b1; ctl.kind = jsu_pkg::KIND_ERR;
							ctl.err = jsu_pkg::E_TRUNC_UNI; done = 1'b1;
						end else begin
							restart = 1'b1; rs_phase = jsu_pkg::PH_HEX1;
						end
					end
					default: begin
						has_ctl = 1'b1; ctl.kind = jsu_pkg::KIND_ERR;
						ctl.err = jsu_pkg::E_BAD_ESC; done = 1'b1;
					end
				endcase
				// after a simple escape drop back to normal characters
				if (nd != 3'd0) begin
					restart = 1'b1;
				end
			end
			jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
				nx_code_unit = cu_new;
				nx_bad_hex   = bad_new;
				if (hex_cnt_q != 2'd3) begin
					// gather another digit; a line end here truncates the escape
					nx_hex_cnt = hex_cnt_q + 2'd1;
					if (end_of_line) begin
						has_ctl = 1'b1; ctl.kind = jsu_pkg::KIND_ERR;
						ctl.err = jsu_pkg::E_TRUNC_UNI; done = 1'b1;
					end
				end else if (bad_new) begin
					has_ctl = 1'b1; ctl.kind = jsu_pkg::KIND_ERR;
					ctl.err = jsu_pkg::E_BAD_HEX; done = 1'b1;
				end else if (phase_q == jsu_pkg::PH_HEX2) begin
					if (cu_new[15:10] != jsu_pkg::LO_SURR_TAG) begin
						has_ctl = 1'b1; ctl.kind = jsu_pkg::KIND_ERR;
						ctl.err = jsu_pkg::E_BAD_LOW; done = 1'b1;
					end else begin
						nd = utf8.len; db = utf8.bytes; restart = 1'b1;
					end
				end else if (cu_new[15:10] == jsu_pkg::HI_SURR_TAG) begin
					if (end_of_line) begin
						has_ctl = 1'b1; ctl.kind = jsu_pkg::KIND_ERR;
						ctl.err = jsu_pkg::E_NO_LOW; done = 1'b1;
					end else begin
						nx_hi_bits = cu_new[9:0];
						restart    = 1'b1;
						rs_phase   = jsu_pkg::PH_WANT_BSL;
					end
				end else if (cu_new[15:10] == jsu_pkg::LO_SURR_TAG) begin
					has_ctl = 1'b1; ctl.kind = jsu_pkg::KIND_ERR;
					ctl.err = jsu_pkg::E_LONE_LOW; done = 1'b1;
				end else begin
					nd = utf8.len; db = utf8.bytes; restart = 1'b1;
				end
			end
			jsu_pkg::PH_WANT_BSL: begin
				if (in_byte != jsu_pkg::CH_BSL || end_of_line) begin
					has_ctl = 1'b1; ctl.kind = jsu_pkg::KIND_ERR;
					ctl.err = jsu_pkg::E_NO_LOW; done = 1'b1;
				end else begin
					nx_phase = jsu_pkg::PH_WANT_U;
				end
			end
			jsu_pkg::PH_WANT_U: begin
				if (in_byte != jsu_pkg::CH_U) begin
					has_ctl = 1'b1; ctl.kind = jsu_pkg::KIND_ERR;
					ctl.err = jsu_pkg::E_NO_LOW; done = 1'b1;
				end else if (end_of_line) begin
					has_ctl = 1'b1; ctl.kind = jsu_pkg::KIND_ERR;
					ctl.err = jsu_pkg::E_TRUNC_UNI; done = 1'b1;
				end else begin
					restart = 1'b1; rs_phase = jsu_pkg::PH_HEX2;
				end
			end
			default: begin
				// normal character phase
				if (in_byte == jsu_pkg::CH_QUOTE) begin
					has_ctl = 1'b1; ctl.kind = jsu_pkg::KIND_END; done = 1'b1;
				end else if (in_byte == jsu_pkg::CH_BSL) begin
					if (end_of_line) begin
						has_ctl = 1'b1; ctl.kind = jsu_pkg::KIND_ERR;
						ctl.err = jsu_pkg::E_TRUNC_ESC; done = 1'b1;
					end else begin
						nx_phase = jsu_pkg::PH_ESC;
					end
				end else begin
					nd = 3'd1; db[0] = in_byte; restart = 1'b1;
				end
			end
		endcase

		// data on the last byte of the line means the string never closed
		if (nd != 3'd0 && end_of_line) begin
			done = 1'b1;
		end
		if (done) begin
			restart  = 1'b1;
			rs_phase = jsu_pkg::PH_NORMAL;
		end
		if (restart) begin
			nx_phase     = rs_phase;
			nx_hex_cnt   = 2'd0;
			nx_code_unit = 16'h0000;
			nx_bad_hex   = 1'b0;
		end
	end

	// Assemble the result words: data bytes, then an unterminated error if
	// the line ended; or a single end / error word.
	always_comb begin
		for (int i = 0; i < jsu_pkg::MaxRes; i++) begin
			res_d[i] = '{kind: jsu_pkg::KIND_ERR, data: 8'h00, err: jsu_pkg::E_UNTERM};
			if (i < 4 && 3'(i) < nd) begin
				res_d[i] = '{kind: jsu_pkg::KIND_DATA, data: db[i[1:0]],
				             err: jsu_pkg::E_BAD_HEX};
			end
		end
		if (nd == 3'd0) begin
			res_d[0] = ctl;
			n_d      = has_ctl ? 3'd1 : 3'd0;
		end else begin
			n_d = nd + {2'b00, end_of_line};
		end
	end

	// Parser state and drain control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= jsu_pkg::PH_NORMAL;
			hex_cnt_q   <= 2'd0;
			code_unit_q <= 16'h0000;
			hi_bits_q   <= 10'h000;
			bad_hex_q   <= 1'b0;
			cnt_q       <= 3'd0;
			pos_q       <= 3'd0;
		end else begin
			if (in_fire) begin
				phase_q     <= nx_phase;
				hex_cnt_q   <= nx_hex_cnt;
				code_unit_q <= nx_code_unit;
				hi_bits_q   <= nx_hi_bits;
				bad_hex_q   <= nx_bad_hex;
				cnt_q       <= n_d;
				pos_q       <= 3'd0;
			end else if (drain_done) begin
				cnt_q <= 3'd0;
				pos_q <= 3'd0;
			end else if (out_fire) begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	// Result payload, loaded on acceptance
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < jsu_pkg::MaxRes; i++) begin
				bundle_s1[i] <= res_d[i];
			end
		end
	end

endmodule

`default_nettype wire
